// ===== hw/rtl/dfdc_pkg.sv =====
// shared types and constants for the decimal fraction digit counter
package dfdc_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 15;

    // 2^52 + 2^51 as a 53-bit significand with scale 2^0
    localparam logic [52:0] MAGIC_SIG = 53'h18000000000000;

    localparam logic [10:0] EXP_ONES = 11'h7FF;

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL10
    } fop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_W,
        ST_SUB,
        ST_SUB_W,
        ST_CHECK,
        ST_MUL_W,
        ST_MUL_GET
    } state_t;

    // unrounded value: sig * 2^scale
    typedef struct packed {
        logic               sign;
        logic signed [12:0] scale;
        logic [63:0]        sig;
        logic               keep_sign;
        logic               pass;
        logic [63:0]        pass_val;
    } fpu_raw_t;

endpackage

// ===== hw/rtl/dfdc_fpu.sv =====
// two-stage binary64 unit: add or subtract the rounding constant, or scale by ten
module dfdc_fpu
    import dfdc_pkg::*;
(
    input  logic        clk,
    input  fop_t        op,
    input  logic [63:0] a,
    output logic [63:0] res
);

    fpu_raw_t           raw_next;
    fpu_raw_t           raw_reg;
    logic [63:0]        res_next;
    logic [63:0]        res_reg;

    logic               a_sign;
    logic [10:0]        a_exp;
    logic [52:0]        a_sig;
    logic signed [12:0] a_e;
    logic               b_sign;
    logic               a_big;
    logic               big_sign;
    logic               small_sign;
    logic [52:0]        big_sig;
    logic [52:0]        small_sig;
    logic signed [12:0] big_e;
    logic signed [12:0] small_e;
    logic signed [12:0] d;
    logic [5:0]         dd;
    logic [55:0]        sm_ext;
    logic [55:0]        shifted;
    logic [55:0]        al;
    logic [56:0]        mag;
    logic [56:0]        prod;

    logic [63:0]        n0;
    logic [63:0]        n1;
    logic [63:0]        n2;
    logic [63:0]        n3;
    logic [63:0]        n4;
    logic [63:0]        n5;
    logic [63:0]        n6;
    logic [5:0]         lz;
    logic signed [13:0] e_b;
    logic signed [13:0] sh_full;
    logic [5:0]         sh;
    logic [63:0]        sig2;
    logic [63:0]        sig_sh;
    logic [12:0]        base;
    logic [52:0]        mant;
    logic               inc;
    logic [53:0]        mant_r;
    logic [64:0]        packed_sum;

    // stage one: align and add, or multiply
    always_comb
    begin
        a_sign     = a[63];
        a_exp      = a[62:52];
        a_sig      = {(a_exp != 11'd0), a[51:0]};
        a_e        = $signed({2'b00, ((a_exp == 11'd0) ? 11'd1 : a_exp)}) - 13'sd1075;
        b_sign     = (op == FOP_SUB);
        a_big      = (a_e > 13'sd0) || ((a_e == 13'sd0) && (a_sig >= MAGIC_SIG));
        big_sign   = a_big ? a_sign : b_sign;
        small_sign = a_big ? b_sign : a_sign;
        big_sig    = a_big ? a_sig : MAGIC_SIG;
        small_sig  = a_big ? MAGIC_SIG : a_sig;
        big_e      = a_big ? a_e : 13'sd0;
        small_e    = a_big ? 13'sd0 : a_e;
        d          = big_e - small_e;
        dd         = (d >= 13'sd56) ? 6'd56 : d[5:0];
        sm_ext     = {small_sig, 3'b000};
        shifted    = sm_ext >> dd;
        al         = shifted | {55'd0, ((shifted << dd) != sm_ext)};
        if (big_sign ^ small_sign)
        begin
            mag = {1'b0, big_sig, 3'b000} - {1'b0, al};
        end
        else
        begin
            mag = {1'b0, big_sig, 3'b000} + {1'b0, al};
        end
        prod = {1'b0, a_sig, 3'b000} + {3'b000, a_sig, 1'b0};

        raw_next.pass     = (a_exp == EXP_ONES);
        raw_next.pass_val = a;
        case (op)
            FOP_ADD, FOP_SUB:
            begin
                raw_next.sign      = big_sign;
                raw_next.scale     = big_e - 13'sd3;
                raw_next.sig       = {7'd0, mag};
                raw_next.keep_sign = 1'b0;
            end
            FOP_MUL10:
            begin
                raw_next.sign      = a_sign;
                raw_next.scale     = a_e;
                raw_next.sig       = {7'd0, prod};
                raw_next.keep_sign = 1'b1;
            end
            default:
            begin
                raw_next.sign      = a_sign;
                raw_next.scale     = a_e;
                raw_next.sig       = 64'd0;
                raw_next.keep_sign = 1'b1;
            end
        endcase
    end

    // stage two: normalize, round to nearest even, pack
    always_comb
    begin
        n0    = raw_reg.sig;
        lz[5] = (n0[63:32] == 32'd0);
        n1    = lz[5] ? {n0[31:0], 32'd0} : n0;
        lz[4] = (n1[63:48] == 16'd0);
        n2    = lz[4] ? {n1[47:0], 16'd0} : n1;
        lz[3] = (n2[63:56] == 8'd0);
        n3    = lz[3] ? {n2[55:0], 8'd0} : n2;
        lz[2] = (n3[63:60] == 4'd0);
        n4    = lz[2] ? {n3[59:0], 4'd0} : n3;
        lz[1] = (n4[63:62] == 2'd0);
        n5    = lz[1] ? {n4[61:0], 2'd0} : n4;
        lz[0] = !n5[63];
        n6    = lz[0] ? {n5[62:0], 1'b0} : n5;

        e_b     = 14'(raw_reg.scale) - $signed({8'd0, lz}) + 14'sd1086;
        sh_full = 14'sd1 - e_b;
        sh      = (sh_full > 14'sd63) ? 6'd63 : sh_full[5:0];
        if (e_b <= 14'sd0)
        begin
            sig_sh = n6 >> sh;
            sig2   = sig_sh | {63'd0, ((sig_sh << sh) != n6)};
            base   = 13'd0;
        end
        else
        begin
            sig_sh = n6;
            sig2   = n6;
            base   = 13'(e_b - 14'sd1);
        end
        mant       = sig2[63:11];
        inc        = sig2[10] & ((sig2[9:0] != 10'd0) | mant[0]);
        mant_r     = {1'b0, mant} + {53'd0, inc};
        packed_sum = {base, 52'd0} + {11'd0, mant_r};

        if (raw_reg.pass)
        begin
            res_next = raw_reg.pass_val;
        end
        else if (raw_reg.sig == 64'd0)
        begin
            res_next = {raw_reg.keep_sign & raw_reg.sign, 63'd0};
        end
        else if (packed_sum[64:52] >= 13'd2047)
        begin
            res_next = {raw_reg.sign, EXP_ONES, 52'd0};
        end
        else
        begin
            res_next = {raw_reg.sign, packed_sum[62:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/decimal_fraction_digit_counter.sv =====
// top level: digit-count sequencer around the shared binary64 unit
//
//  channel   signals                      handshake
//  input     start, value_bits            taken when start && !busy
//  result    done, digit_count            one-cycle strobe, no back-pressure
//
// a signaling or quiet nan is answered in the cycle after it is taken
// otherwise the answer comes after the last pass
// each pass is add, subtract and scale on the one two-stage binary64 unit
// rst_n clears the sequencer and the strobe at once
// busy stays high until the answer is out; results cannot be stalled
module decimal_fraction_digit_counter
    import dfdc_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value_bits,
    output logic        busy,
    output logic        done,
    output logic [3:0]  digit_count
);

    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [63:0]    work_reg;
    logic [63:0]    work_next;
    logic           done_reg;
    logic           done_next;
    logic [3:0]     digit_count_reg;
    logic [3:0]     digit_count_next;
    fop_t           fop;
    logic [63:0]    fa;
    logic [63:0]    fres;
    logic [63:0]    diff;
    logic           is_nan;
    logic           close;

    dfdc_fpu u_fpu
    (
        .clk (clk),
        .op  (fop),
        .a   (fa),
        .res (fres)
    );

    always_comb
    begin
        is_nan = (value_bits[62:52] == EXP_ONES) && (value_bits[51:0] != 52'd0);
        diff   = fres - work_reg;
        close  = (diff == 64'd0) || (diff == 64'd1) || (diff == 64'd2)
                 || (diff == 64'hFFFF_FFFF_FFFF_FFFF) || (diff == 64'hFFFF_FFFF_FFFF_FFFE);

        state_next       = state_reg;
        count_next       = count_reg;
        work_next        = work_reg;
        done_next        = 1'b0;
        digit_count_next = digit_count_reg;
        fop              = FOP_ADD;
        fa               = work_reg;

        case (state_reg)
            ST_IDLE:
            begin
                fa = value_bits;
                if (start)
                begin
                    if (is_nan)
                    begin
                        done_next        = 1'b1;
                        digit_count_next = value_bits[51] ? 4'd0 : 4'd1;
                    end
                    else
                    begin
                        work_next  = value_bits;
                        count_next = '0;
                        state_next = ST_ADD_W;
                    end
                end
            end
            ST_ADD_W:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                fop        = FOP_SUB;
                fa         = fres;
                state_next = ST_SUB_W;
            end
            ST_SUB_W:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                fop = FOP_MUL10;
                if (close || (count_reg == CW'(MAX_DIGITS)))
                begin
                    done_next        = 1'b1;
                    digit_count_next = 4'(count_reg);
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W:
            begin
                fop        = FOP_MUL10;
                state_next = ST_MUL_GET;
            end
            ST_MUL_GET:
            begin
                fa         = fres;
                work_next  = fres;
                count_next = count_reg + CW'(1);
                state_next = ST_ADD_W;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        digit_count_reg <= digit_count_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign digit_count = digit_count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while still working");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("item taken but neither working nor answered");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_DIGITS))
        else $error("pass count beyond limit");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("work began without start");

endmodule
